// ----- rtl/lmscn_pkg.sv -----
// Shared types and constants of the min-sum check-node unit.
// No dependencies; lmscn_front, lmscn_back, the top level and the bench import it.
package lmscn_pkg;

  // Fixed register widths and reset values
  localparam int NORM_W   = 9;
  localparam int OFFSET_W = 7;
  localparam logic [NORM_W-1:0]   NORM_RESET   = 9'd211;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 7'd0;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = NORM_W;
  localparam logic [CFG_IDX_W-1:0] REG_NORM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;

  // Field widths sized for the largest supported degree and message width
  localparam int CNT_MAX_W = 7;
  localparam int MAG_MAX_W = 15;

  // Depths of the decoupling queues
  localparam int DESC_DEPTH = 2;
  localparam int OUT_DEPTH  = 4;

  // One closed row, handed from the front to the back
  typedef struct packed {
    logic                 bank;
    logic [CNT_MAX_W-1:0] count;
    logic                 parity;
    logic [MAG_MAX_W-1:0] first_min;
    logic [MAG_MAX_W-1:0] second_min;
    logic                 frame_last;
    logic                 fail;
  } row_desc_t;

  // Back tells the front that a bank has been read out
  typedef struct packed {
    logic done;
    logic bank;
  } row_done_t;

endpackage

// ----- rtl/lmscn_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lmscn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lmscn_fifo.sv -----
// Small register FIFO with occupancy count; the head is shown combinationally.
// No dependencies. Callers never push into a full queue.
module lmscn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic             do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop & ~empty;
  assign rdata  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/lmscn_front.sv -----
// Front end: accepts edge messages, writes sign and magnitude into the current bank,
// tracks parity and the two minima, and closes rows into descriptors. Uses lmscn_pkg.
module lmscn_front import lmscn_pkg::*; #(
  parameter int MAX_DEGREE = 32,
  parameter int MSG_BITS   = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [MSG_BITS-1:0]        v2c_msg,
  input  logic                              row_last,
  input  logic                              frame_last,
  output logic                              ram_we,
  output logic [$clog2(MAX_DEGREE):0]       ram_waddr,
  output logic [MSG_BITS-1:0]               ram_wdata,
  output logic                              desc_push,
  output row_desc_t                         desc,
  input  logic                              desc_full,
  input  row_done_t                         done
);

  localparam int MW = MSG_BITS - 1;
  localparam int IW = $clog2(MAX_DEGREE);
  localparam logic [MW-1:0] MAX_MAG = {MW{1'b1}};

  logic          bank;
  logic [1:0]    bank_busy;
  logic [1:0]    bank_busy_next;
  logic [IW-1:0] edge_count;
  logic          sign_parity;
  logic [MW-1:0] first_min;
  logic [MW-1:0] second_min;
  logic          frame_fail;

  logic [MSG_BITS-1:0] raw;
  logic [MSG_BITS-1:0] neg_raw;
  logic                sign_in;
  logic [MW-1:0]       mag_in;
  logic                parity_next;
  logic [MW-1:0]       first_min_next;
  logic [MW-1:0]       hi;
  logic [MW-1:0]       second_min_next;
  logic                fail_next;
  logic                accept;
  logic                close;

  assign raw     = v2c_msg;
  assign neg_raw = ~raw + MSG_BITS'(1);
  assign sign_in = raw[MSG_BITS-1];

  // Most negative code saturates to the largest magnitude
  always_comb begin
    if (!sign_in) begin
      mag_in = raw[MW-1:0];
    end else if (raw[MW-1:0] == '0) begin
      mag_in = MAX_MAG;
    end else begin
      mag_in = neg_raw[MW-1:0];
    end
  end

  assign parity_next     = sign_parity ^ sign_in;
  assign first_min_next  = (mag_in < first_min) ? mag_in : first_min;
  assign hi              = (mag_in > first_min) ? mag_in : first_min;
  assign second_min_next = (hi < second_min) ? hi : second_min;
  assign fail_next       = frame_fail | parity_next;

  assign full   = bank_busy[bank] | desc_full;
  assign accept = push & ~full;
  // A full store closes the row on its own
  assign close  = row_last | frame_last | (edge_count == IW'(MAX_DEGREE - 1));

  assign ram_we    = accept;
  assign ram_waddr = {bank, edge_count};
  assign ram_wdata = {sign_in, mag_in};

  assign desc_push       = accept & close;
  assign desc.bank       = bank;
  assign desc.count      = CNT_MAX_W'(edge_count) + CNT_MAX_W'(1);
  assign desc.parity     = parity_next;
  assign desc.first_min  = MAG_MAX_W'(first_min_next);
  assign desc.second_min = MAG_MAX_W'(second_min_next);
  assign desc.frame_last = frame_last;
  assign desc.fail       = fail_next;

  always_comb begin
    bank_busy_next = bank_busy;
    if (done.done) begin
      bank_busy_next[done.bank] = 1'b0;
    end
    if (desc_push) begin
      bank_busy_next[bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank        <= 1'b0;
      bank_busy   <= '0;
      edge_count  <= '0;
      sign_parity <= 1'b0;
      first_min   <= MAX_MAG;
      second_min  <= MAX_MAG;
      frame_fail  <= 1'b0;
    end else begin
      bank_busy <= bank_busy_next;
      if (accept) begin
        if (close) begin
          bank        <= ~bank;
          edge_count  <= '0;
          sign_parity <= 1'b0;
          first_min   <= MAX_MAG;
          second_min  <= MAX_MAG;
          frame_fail  <= frame_last ? 1'b0 : fail_next;
        end else begin
          edge_count  <= edge_count + IW'(1);
          sign_parity <= parity_next;
          first_min   <= first_min_next;
          second_min  <= second_min_next;
        end
      end
    end
  end

endmodule

// ----- rtl/lmscn_back.sv -----
// Back end: takes closed rows, scales the two minima once per row, then reads the bank
// one edge a cycle while output space lasts; forms the c2v messages. Uses lmscn_pkg.
module lmscn_back import lmscn_pkg::*; #(
  parameter int MAX_DEGREE = 32,
  parameter int MSG_BITS   = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [NORM_W-1:0]                  norm_factor,
  input  logic [OFFSET_W-1:0]                offset_value,
  input  logic                               desc_empty,
  output logic                               desc_pop,
  input  row_desc_t                          desc,
  output row_done_t                          done,
  output logic                               ram_re,
  output logic [$clog2(MAX_DEGREE):0]        ram_raddr,
  input  logic [MSG_BITS-1:0]                ram_rdata,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
  output logic                               out_push,
  output logic [MSG_BITS-1:0]                out_msg,
  output logic                               out_row_end,
  output logic                               out_parity,
  output logic                               out_frame_ok
);

  localparam int MW  = MSG_BITS - 1;
  localparam int IW  = $clog2(MAX_DEGREE);
  localparam int CW  = $clog2(MAX_DEGREE + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam int WW  = (MW > OFFSET_W) ? MW : OFFSET_W;
  localparam int PW  = MW + NORM_W;
  localparam logic [MW-1:0] MAX_MAG = {MW{1'b1}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCALE,
    S_EMIT
  } state_t;

  state_t        state;
  row_desc_t     cur;
  logic [MW-1:0] c1;
  logic [MW-1:0] c2;
  logic [IW-1:0] idx;
  logic          rd_pend;
  logic          rd_last;

  logic            issue;
  logic            last_issue;
  logic [OCW:0]    reserved;
  logic            e_sign;
  logic [MW-1:0]   e_mag;
  logic [MW-1:0]   m_sel;
  logic            neg;
  logic [MSG_BITS-1:0] m_ext;

  // max(0, m - offset) * norm >> 8, clipped to the largest magnitude
  function automatic logic [MW-1:0] scale_mag(input logic [MW-1:0] m,
                                              input logic [OFFSET_W-1:0] off,
                                              input logic [NORM_W-1:0] norm);
    logic [WW-1:0] mw;
    logic [WW-1:0] ow;
    logic [WW-1:0] d;
    logic [PW-1:0] prod;
    logic [MW:0]   r;
    mw   = WW'(m);
    ow   = WW'(off);
    d    = (mw > ow) ? (mw - ow) : '0;
    prod = PW'(d[MW-1:0]) * PW'(norm);
    r    = prod[PW-1:8];
    return (r > (MW+1)'(MAX_MAG)) ? MAX_MAG : r[MW-1:0];
  endfunction

  assign reserved   = (OCW+1)'(out_count) + (OCW+1)'(rd_pend);
  assign issue      = (state == S_EMIT) && (reserved < (OCW+1)'(OUT_DEPTH));
  assign last_issue = (CW'(idx) + CW'(1)) == cur.count[CW-1:0];

  assign desc_pop  = (state == S_IDLE) && !desc_empty;
  assign done.done = issue & last_issue;
  assign done.bank = cur.bank;
  assign ram_re    = issue;
  assign ram_raddr = {cur.bank, idx};

  // Read data of the edge issued in the previous cycle
  assign e_sign = ram_rdata[MSG_BITS-1];
  assign e_mag  = ram_rdata[MW-1:0];
  assign m_sel  = (e_mag == cur.first_min[MW-1:0]) ? c1 : c2;
  assign neg    = cur.parity ^ e_sign;
  assign m_ext  = {1'b0, m_sel};

  assign out_push     = rd_pend;
  assign out_msg      = (neg && (m_sel != '0)) ? (~m_ext + MSG_BITS'(1)) : m_ext;
  assign out_row_end  = rd_last;
  assign out_parity   = cur.parity;
  assign out_frame_ok = rd_last & cur.frame_last & ~cur.fail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      rd_pend <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      rd_pend <= issue;
      rd_last <= issue & last_issue;
      unique case (state)
        S_IDLE: begin
          if (desc_pop) begin
            cur   <= desc;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          c1    <= scale_mag(cur.second_min[MW-1:0], offset_value, norm_factor);
          c2    <= scale_mag(cur.first_min[MW-1:0], offset_value, norm_factor);
          idx   <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (issue) begin
            idx <= idx + IW'(1);
            if (last_issue) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ldpc_min_sum_check_node_unit.sv -----
// Top level of the normalized offset min-sum check-node unit.
// Depends on lmscn_pkg, lmscn_ram, lmscn_fifo, lmscn_front and lmscn_back.
//
// Edge messages enter one a cycle while full is low. Each row is written into one of two
// banks of the edge RAM, so one row fills while the previous one drains. Once a row closes
// (row_last, frame_last or a full bank store) its first result reaches the
// result ports through the row handoff, scaling multiply, RAM read and output queue write,
// then one result a cycle follows while the output queue has room, limited by the single
// RAM read port. Input stalls (full) only while both banks hold rows still being read out.
// Results wait in a four-deep output queue. There is no clearing pass after reset.
module ldpc_min_sum_check_node_unit import lmscn_pkg::*; #(
  parameter int MAX_DEGREE = 32,
  parameter int MSG_BITS   = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [MSG_BITS-1:0] v2c_msg,
  input  logic                       row_last,
  input  logic                       frame_last,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [MSG_BITS-1:0] c2v_msg,
  output logic                       row_end,
  output logic                       row_parity_odd,
  output logic                       frame_ok,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW   = $clog2(MAX_DEGREE) + 1;
  localparam int DCW  = $clog2(DESC_DEPTH + 1);
  localparam int OCW  = $clog2(OUT_DEPTH + 1);
  localparam int OUTW = MSG_BITS + 3;

  logic [NORM_W-1:0]   norm_factor;
  logic [OFFSET_W-1:0] offset_value;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [MSG_BITS-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [MSG_BITS-1:0] ram_rdata;

  logic                    desc_push;
  row_desc_t               desc_in;
  row_desc_t               desc_out;
  logic [$bits(row_desc_t)-1:0] desc_rd;
  logic                    desc_pop;
  logic                    desc_empty;
  logic [DCW-1:0]          desc_count;
  logic                    desc_full;
  row_done_t               done;

  logic                out_push;
  logic [MSG_BITS-1:0] out_msg;
  logic                out_row_end;
  logic                out_parity;
  logic                out_frame_ok;
  logic [OUTW-1:0]     out_rd;
  logic [OCW-1:0]      out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_factor  <= NORM_RESET;
      offset_value <= OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NORM:   norm_factor  <= cfg_data;
        REG_OFFSET: offset_value <= cfg_data[OFFSET_W-1:0];
        default:    ;
      endcase
    end
  end

  lmscn_ram #(
    .WIDTH (MSG_BITS),
    .DEPTH (1 << AW)
  ) u_edge_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lmscn_front #(
    .MAX_DEGREE (MAX_DEGREE),
    .MSG_BITS   (MSG_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .v2c_msg    (v2c_msg),
    .row_last   (row_last),
    .frame_last (frame_last),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .desc_push  (desc_push),
    .desc       (desc_in),
    .desc_full  (desc_full),
    .done       (done)
  );

  assign desc_full = (desc_count == DCW'(DESC_DEPTH));
  assign desc_out  = desc_rd;

  lmscn_fifo #(
    .WIDTH ($bits(row_desc_t)),
    .DEPTH (DESC_DEPTH)
  ) u_desc_q (
    .clk   (clk),
    .rst   (rst),
    .push  (desc_push),
    .wdata (desc_in),
    .pop   (desc_pop),
    .rdata (desc_rd),
    .empty (desc_empty),
    .count (desc_count)
  );

  lmscn_back #(
    .MAX_DEGREE (MAX_DEGREE),
    .MSG_BITS   (MSG_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .norm_factor  (norm_factor),
    .offset_value (offset_value),
    .desc_empty   (desc_empty),
    .desc_pop     (desc_pop),
    .desc         (desc_out),
    .done         (done),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .out_count    (out_count),
    .out_push     (out_push),
    .out_msg      (out_msg),
    .out_row_end  (out_row_end),
    .out_parity   (out_parity),
    .out_frame_ok (out_frame_ok)
  );

  lmscn_fifo #(
    .WIDTH (OUTW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata ({out_msg, out_row_end, out_parity, out_frame_ok}),
    .pop   (pop),
    .rdata (out_rd),
    .empty (empty),
    .count (out_count)
  );

  assign c2v_msg        = out_rd[OUTW-1:3];
  assign row_end        = out_rd[2];
  assign row_parity_odd = out_rd[1];
  assign frame_ok       = out_rd[0];

endmodule

// ----- bench/ldpc_min_sum_check_node_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the min-sum check-node unit. It runs directed rows, then random
// frames under several register settings, and scores every result beat against a row predictor
// or a pinned table value. Depends on lmscn_pkg and the RTL of ldpc_min_sum_check_node_unit.
module ldpc_min_sum_check_node_unit_tb;
  import lmscn_pkg::*;

  localparam int ROW_MAX        = 32;
  localparam int LLR_W          = 8;
  localparam int LLR_MAX        = 127;
  localparam int PHASES         = 8;
  localparam int PHASE_EDGES    = 6;
  localparam int DRAIN_CYCLES   = ROW_MAX + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DIR_N          = 21;
  // (127 * 211) >> 8: the full magnitude scaled with the reset registers
  localparam int MAX_SCALED_RST = 104;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [LLR_W-1:0] c2v;
    logic             row_end;
    logic             odd;
    logic             ok;
  } c2v_beat_t;

  typedef struct packed {
    logic [LLR_W-1:0] llr;
    logic             row_last;
    logic             frame_last;
    logic             pinned;
    c2v_beat_t        want;
  } dir_edge_t;

  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    push       = 1'b0;
  logic signed [LLR_W-1:0] v2c_msg    = '0;
  logic                    row_last   = 1'b0;
  logic                    frame_last = 1'b0;
  logic                    pop        = 1'b0;
  logic                    cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_DATA_W-1:0]   cfg_data   = '0;
  logic                    full;
  logic                    empty;
  logic signed [LLR_W-1:0] c2v_msg;
  logic                    row_end;
  logic                    row_parity_odd;
  logic                    frame_ok;

  // Predictor state: the open row, its minima and parity, the frame flag, the registers
  logic [LLR_W-1:0] row_llrs [ROW_MAX];
  int               row_fill  = 0;
  logic             row_odd   = 1'b0;
  int               min1      = LLR_MAX;
  int               min2      = LLR_MAX;
  logic             frame_bad = 1'b0;
  int               norm_q    = NORM_RESET;
  int               off_q     = OFFSET_RESET;

  c2v_beat_t fresh_beats [$];
  c2v_beat_t pending_c2v [$];
  int        err_count   = 0;
  int        idle_cycles = 0;
  int        stall_left  = 0;
  logic      tx_calm     = 1'b0;
  logic      rx_calm     = 1'b0;

  int norm_set [PHASES] = '{256, 0, 511, 211, 128, 300, -1, 211};
  int off_set  [PHASES] = '{0, 0, 0, 127, 3, 10, -1, 0};

  dir_edge_t dir_tab [DIR_N] = '{
    // single-edge rows: second minimum stays at full scale
    '{8'h05, 1'b1, 1'b0, 1'b1, '{LLR_W'(MAX_SCALED_RST), 1'b1, 1'b0, 1'b0}},
    '{8'h80, 1'b1, 1'b1, 1'b1, '{LLR_W'(MAX_SCALED_RST), 1'b1, 1'b1, 1'b0}},
    '{8'h7F, 1'b1, 1'b1, 1'b1, '{LLR_W'(MAX_SCALED_RST), 1'b1, 1'b0, 1'b1}},
    '{8'h00, 1'b1, 1'b0, 1'b1, '{LLR_W'(MAX_SCALED_RST), 1'b1, 1'b0, 1'b0}},
    // extremes with a zero edge, so negative edges get zero magnitude
    '{8'h80, 1'b0, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
    // tie on the first minimum
    '{8'h03, 1'b0, 1'b0, 1'b0, '0},
    '{8'hFD, 1'b0, 1'b0, 1'b0, '0},
    '{8'h07, 1'b1, 1'b0, 1'b0, '0},
    // frame end closes the row on its own
    '{8'hFB, 1'b0, 1'b0, 1'b0, '0},
    '{8'h09, 1'b0, 1'b1, 1'b0, '0},
    // odd row, then a frame that must report failure
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{8'h40, 1'b1, 1'b0, 1'b0, '0},
    '{8'h02, 1'b1, 1'b1, 1'b0, '0},
    // clean frame after the failed one
    '{8'h7E, 1'b0, 1'b0, 1'b0, '0},
    '{8'h81, 1'b0, 1'b0, 1'b0, '0},
    '{8'h81, 1'b1, 1'b1, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, 1'b0, '0}
  };

  ldpc_min_sum_check_node_unit #(
    .MAX_DEGREE(ROW_MAX),
    .MSG_BITS  (LLR_W)
  ) DUT (.*);

  always #6 clk = ~clk;

  function automatic int llr_mag(logic [LLR_W-1:0] raw);
    int m;
    m = raw[LLR_W-1] ? (1 << LLR_W) - int'(raw) : int'(raw);
    return (m > LLR_MAX) ? LLR_MAX : m;
  endfunction

  function automatic int scaled_mag(int m);
    int d;
    int r;
    d = (m > off_q) ? m - off_q : 0;
    r = (d * norm_q) >> 8;
    return (r > LLR_MAX) ? LLR_MAX : r;
  endfunction

  // Absorb one edge; on row close, fill fresh_beats with the row's burst
  function automatic void min_sum_update(logic [LLR_W-1:0] raw, logic rl, logic fl);
    int        a;
    int        hi;
    int        c_second;
    int        c_first;
    int        m;
    int        k;
    logic      fail;
    logic      neg;
    c2v_beat_t b;
    fresh_beats = {};
    if (row_fill < ROW_MAX) begin
      row_llrs[row_fill] = raw;
      row_fill++;
    end
    row_odd ^= raw[LLR_W-1];
    a = llr_mag(raw);
    hi = (a > min1) ? a : min1;
    if (a < min1) min1 = a;
    if (hi < min2) min2 = hi;
    if (!rl && !fl && row_fill < ROW_MAX) return;
    c_second = scaled_mag(min2);
    c_first = scaled_mag(min1);
    fail = frame_bad | row_odd;
    for (k = 0; k < row_fill; k++) begin
      m = (llr_mag(row_llrs[k]) == min1) ? c_second : c_first;
      neg = row_odd ^ row_llrs[k][LLR_W-1];
      b.c2v = (neg && m != 0) ? LLR_W'(-m) : LLR_W'(m);
      b.row_end = (k == row_fill - 1);
      b.odd = row_odd;
      b.ok = (fl && b.row_end) ? !fail : 1'b0;
      fresh_beats.push_back(b);
    end
    frame_bad = fl ? 1'b0 : fail;
    row_fill = 0;
    row_odd = 1'b0;
    min1 = LLR_MAX;
    min2 = LLR_MAX;
  endfunction

  function automatic int idle_len(logic calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int row_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 6);
    if (r < 18) return $urandom_range(7, ROW_MAX - 1);
    return $urandom_range(ROW_MAX, ROW_MAX + 8);
  endfunction

  function automatic logic [LLR_W-1:0] pick_llr(logic [LLR_W-1:0] prev);
    logic [LLR_W-1:0] corner [6];
    corner = '{8'h80, 8'h81, 8'h7F, 8'h00, 8'h01, 8'hFF};
    case ($urandom_range(0, 4))
      0, 1: return LLR_W'($urandom);
      2: return LLR_W'($urandom_range(0, 8) - 4);
      3: return corner[$urandom_range(0, 5)];
      default: return $urandom_range(0, 1) ? prev : -prev;
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  function automatic void score_beat();
    c2v_beat_t want;
    if (pending_c2v.size() == 0) begin
      $display("%0t: unexpected result beat, c2v_msg %0d row_end %b", $time, c2v_msg, row_end);
      err_count++;
      return;
    end
    want = pending_c2v.pop_front();
    check_field("c2v_msg", $signed(want.c2v), c2v_msg);
    check_field("row_end", want.row_end, row_end);
    check_field("row_parity_odd", want.odd, row_parity_odd);
    check_field("frame_ok", want.ok, frame_ok);
  endfunction

  // Offer one edge, hold it until accepted, then log what it produces
  task automatic send_edge(input logic [LLR_W-1:0] raw, input logic rl, input logic fl,
                           input logic pinned = 1'b0, input c2v_beat_t want = '0);
    int gap;
    gap = idle_len(tx_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    v2c_msg <= raw;
    row_last <= rl;
    frame_last <= fl;
    do @(posedge clk); while (full);
    min_sum_update(raw, rl, fl);
    if (pinned) begin
      pending_c2v.push_back(want);
    end else begin
      foreach (fresh_beats[i]) pending_c2v.push_back(fresh_beats[i]);
    end
  endtask

  task automatic drain_rows();
    push <= 1'b0;
    while (pending_c2v.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input int norm, input int off);
    cfg_write <= 1'b1;
    cfg_index <= REG_NORM;
    cfg_data <= CFG_DATA_W'(norm);
    @(posedge clk);
    // junk above the offset field must be dropped
    cfg_index <= REG_OFFSET;
    cfg_data <= CFG_DATA_W'(($urandom << OFFSET_W) | off);
    @(posedge clk);
    cfg_index <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
    cfg_data <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
    norm_q = norm;
    off_q = off;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left <= 0;
    end else begin
      if (pop && !empty) score_beat();
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        pop <= 1'b1;
        stall_left <= idle_len(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int               ph;
    int               len;
    int               k;
    int               sent;
    int               norm;
    int               off;
    logic             rl;
    logic             fl;
    logic [LLR_W-1:0] prev_llr;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_tab[i]) begin
      send_edge(dir_tab[i].llr, dir_tab[i].row_last, dir_tab[i].frame_last,
                dir_tab[i].pinned, dir_tab[i].want);
    end
    prev_llr = '0;
    for (ph = 0; ph < PHASES; ph++) begin
      drain_rows();
      norm = (norm_set[ph] < 0) ? $urandom_range(0, 511) : norm_set[ph];
      off = (off_set[ph] < 0) ? $urandom_range(0, 127) : off_set[ph];
      program_regs(norm, off);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_EDGES) begin
        // open with an overlong row so the store-full close is hit unless a random close cuts it
        len = (ph == 0 && sent == 0) ? ROW_MAX + 2 : row_len();
        for (k = 0; k < len; k++) begin
          rl = (k == len - 1);
          fl = rl && ($urandom_range(0, 3) == 0);
          if (rl && $urandom_range(0, 7) == 0) begin
            rl = 1'b0;
            fl = 1'b1;
          end
          if ($urandom_range(0, 19) == 0) begin
            rl = $urandom_range(0, 1);
            fl = ($urandom_range(0, 3) == 0);
          end
          prev_llr = pick_llr(prev_llr);
          send_edge(prev_llr, rl, fl);
          sent++;
        end
      end
      // close any row left open before the registers change
      if (row_fill != 0) send_edge(pick_llr(prev_llr), 1'b1, 1'b0);
    end
    drain_rows();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- ldpc_min_sum_check_node_unit.f -----
rtl/lmscn_pkg.sv
rtl/lmscn_ram.sv
rtl/lmscn_fifo.sv
rtl/lmscn_front.sv
rtl/lmscn_back.sv
rtl/ldpc_min_sum_check_node_unit.sv
bench/ldpc_min_sum_check_node_unit_tb.sv
